/* rtl/core/fsmt_pkg.sv */
package fsmt_pkg;

	localparam int DEF_REL_SLOTS = 8;
	localparam int DEF_BLOCKS    = 256;
	localparam int CAT_W         = 8;
	localparam int ENTRY_W       = CAT_W + 1;
	localparam logic [31:0] NO_BLOCK = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		CMD_RECORD   = 3'd0,
		CMD_SEARCH   = 3'd1,
		CMD_TRUNCATE = 3'd2,
		CMD_DROP     = 3'd3,
		CMD_CLEAR    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_OOR  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_TRUNC,
		ST_DROP,
		ST_WIPE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] tablespace_id;
		logic [31:0] database_id;
		logic [31:0] relation_number;
	} key_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [31:0]      tablespace_id;
		logic [31:0]      database_id;
		logic [31:0]      relation_number;
		logic [31:0]      block;
		logic [CAT_W-1:0] category;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] found_block;
		logic [8:0]  removed_count;
		logic [3:0]  relation_count;
	} rsp_t;

endpackage

/* rtl/core/fsmt_if.sv */
interface fsmt_req_if;
	import fsmt_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fsmt_rsp_if;
	import fsmt_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/fsmt_ram.sv */
module fsmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read of the address being written returns the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

/* rtl/core/free_space_map_table_unit.sv */
// Free-space map for a bounded set of relations.
// req: one command per transfer (record, search, truncate, drop, clear all)
//   with the relation key, a block number and a category.
// rsp: one result per command (status, search hit, dropped entry count and
//   number of relations held).
// cfg_we/cfg_wdata: category clamp; write it only while idle (unchecked).
// Per-block entries live in one RAM of REL_SLOTS x 2^ceil(log2 BLOCKS) words,
// one read and one write port; relation keys sit in flip-flops.
// Record and miss cases go from the lookup state straight to the done state.
// Search walks the relation's blocks, one read a cycle.
// Truncate writes one entry a cycle from the count. Drop reads and clears
// one entry a cycle. Clear all sweeps the whole RAM.
// One command is in work at a time; the next is taken while a finished
// result still waits. A stalled rsp holds its result; a newer result waits
// in the done state until the output register frees.
// After reset the RAM is swept clean (REL_SLOTS * 2^ceil(log2 BLOCKS)
// words, 2048 by default) before req.ready rises.
module free_space_map_table_unit #(
	parameter int REL_SLOTS = fsmt_pkg::DEF_REL_SLOTS,
	parameter int BLOCKS    = fsmt_pkg::DEF_BLOCKS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [fsmt_pkg::CAT_W-1:0] cfg_wdata,
	fsmt_req_if.sink                req,
	fsmt_rsp_if.source              rsp
);
	import fsmt_pkg::*;

	localparam int SW    = (REL_SLOTS > 1) ? $clog2(REL_SLOTS) : 1;
	localparam int BW    = $clog2(BLOCKS);
	localparam int DEPTH = REL_SLOTS << BW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(BLOCKS + 1);
	localparam logic [AW:0] BLK_END  = (AW + 1)'(BLOCKS);
	localparam logic [AW:0] BLK_LAST = (AW + 1)'(BLOCKS - 1);
	localparam logic [AW:0] RAM_LAST = (AW + 1)'(DEPTH - 1);

	state_t state_q, state_d;

	logic [2:0]       cmd_q;
	key_t             key_in_q;
	logic [31:0]      blk_q;
	logic [CAT_W-1:0] cat_q;
	logic [CAT_W-1:0] max_cat_q;

	logic [REL_SLOTS-1:0] slot_valid_q;
	key_t                 slot_key_q [REL_SLOTS];
	logic [SW-1:0]        slot_q;

	logic [AW:0]   cnt_q;
	logic          rd_s1;
	logic [BW-1:0] idx_s1;

	logic [1:0]    status_q;
	logic          found_q;
	logic [BW-1:0] fblk_q;
	logic [CW-1:0] rem_q;

	logic rsp_vld_q;
	rsp_t rsp_q;

	// RAM port control
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

	// relation lookup over the slot keys
	logic          hit, free_any;
	logic [SW-1:0] hit_idx, free_idx;
	logic          blk_oob;
	logic [CAT_W-1:0] cat_clamped;
	logic          entry_match;
	logic          req_xfer, rsp_free;

	assign req_xfer = req.valid && req.ready;
	assign rsp_free = !rsp_vld_q || rsp.ready;
	assign blk_oob  = blk_q >= 32'(BLOCKS);
	assign cat_clamped = (cat_q > max_cat_q) ? max_cat_q : cat_q;
	assign entry_match = mem_rdata[ENTRY_W-1] && (mem_rdata[CAT_W-1:0] >= cat_q);

	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int s = REL_SLOTS - 1; s >= 0; s--) begin
			if (slot_valid_q[s] && slot_key_q[s] == key_in_q) begin
				hit     = 1'b1;
				hit_idx = SW'(s);
			end
			if (!slot_valid_q[s]) begin
				free_any = 1'b1;
				free_idx = SW'(s);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT, ST_WIPE: begin
				if (cnt_q == RAM_LAST) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (req_xfer) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				case (cmd_q)
					CMD_SEARCH:   state_d = hit ? ST_SCAN : ST_DONE;
					CMD_TRUNCATE: state_d = (hit && !blk_oob) ? ST_TRUNC : ST_DONE;
					CMD_DROP:     state_d = hit ? ST_DROP : ST_DONE;
					CMD_CLEAR:    state_d = ST_WIPE;
					default:      state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				if ((rd_s1 && entry_match) || (cnt_q == BLK_END && !rd_s1)) begin
					state_d = ST_DONE;
				end
			end
			ST_TRUNC: begin
				if (cnt_q == BLK_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DROP: begin
				if (cnt_q == BLK_END && !rd_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine: RAM accesses
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = AW'({slot_q, cnt_q[BW-1:0]});
		unique case (state_q)
			ST_INIT, ST_WIPE: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
			end
			ST_LOOKUP: begin
				if (cmd_q == CMD_RECORD && !blk_oob && (hit || free_any)) begin
					mem_we    = 1'b1;
					mem_waddr = AW'({hit ? hit_idx : free_idx, blk_q[BW-1:0]});
					mem_wdata = {1'b1, cat_clamped};
				end
			end
			ST_SCAN: begin
				mem_re = cnt_q < BLK_END;
			end
			ST_TRUNC: begin
				mem_we    = 1'b1;
				mem_waddr = AW'({slot_q, cnt_q[BW-1:0]});
			end
			ST_DROP: begin
				mem_re    = cnt_q < BLK_END;
				mem_we    = mem_re;
				mem_waddr = AW'({slot_q, cnt_q[BW-1:0]});
			end
			default: ;
		endcase
	end

	fsmt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cat_q <= '1;
		end else if (cfg_we) begin
			max_cat_q <= cfg_wdata;
		end
	end

	// command fields, latched at the transfer
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_q    <= req.data.cmd;
			key_in_q <= '{req.data.tablespace_id, req.data.database_id,
				req.data.relation_number};
			blk_q    <= req.data.block;
			cat_q    <= req.data.category;
		end
	end

	// slot keys carry no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP && cmd_q == CMD_RECORD && !blk_oob && !hit && free_any) begin
			slot_key_q[free_idx] <= key_in_q;
		end
	end

	// control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			slot_valid_q <= '0;
			slot_q       <= '0;
			cnt_q        <= '0;
			rd_s1        <= 1'b0;
			idx_s1       <= '0;
			status_q     <= STAT_OK;
			found_q      <= 1'b0;
			fblk_q       <= '0;
			rem_q        <= '0;
			rsp_vld_q    <= 1'b0;
			rsp_q        <= '0;
		end else begin
			state_q <= state_d;
			rd_s1   <= mem_re;
			idx_s1  <= cnt_q[BW-1:0];
			// output register: filled from the done state, emptied by a transfer
			if (state_q == ST_DONE && rsp_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT, ST_WIPE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == RAM_LAST) begin
						slot_valid_q <= '0;
					end
				end
				ST_IDLE: begin
					status_q <= STAT_OK;
					found_q  <= 1'b0;
					rem_q    <= '0;
					cnt_q    <= '0;
				end
				ST_LOOKUP: begin
					slot_q <= hit ? hit_idx : free_idx;
					if (cmd_q == CMD_TRUNCATE) begin
						cnt_q <= (AW + 1)'(blk_q[BW-1:0]);
					end
					if (cmd_q == CMD_RECORD) begin
						if (blk_oob) begin
							status_q <= STAT_OOR;
						end else if (!hit && !free_any) begin
							status_q <= STAT_FULL;
						end else if (!hit) begin
							slot_valid_q[free_idx] <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_s1 && entry_match) begin
						found_q <= 1'b1;
						fblk_q  <= idx_s1;
					end
				end
				ST_TRUNC: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ST_DROP: begin
					if (mem_re) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_s1 && mem_rdata[ENTRY_W-1]) begin
						rem_q <= rem_q + 1'b1;
					end
					if (state_d == ST_DONE) begin
						slot_valid_q[slot_q] <= 1'b0;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_q.status             <= status_q;
						rsp_q.found              <= found_q;
						rsp_q.found_block        <= found_q ? 32'(fblk_q) : NO_BLOCK;
						rsp_q.removed_count      <= 9'(rem_q);
						rsp_q.relation_count     <= 4'($countones(slot_valid_q));
					end
				end
				default: ;
			endcase
		end
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign rsp.valid  = rsp_vld_q;
	assign rsp.data   = rsp_q;

	// while a search walks, the RAM is only read, never written
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("entry RAM written during search");

	// a finished drop leaves its slot free
	a_drop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DROP && state_d == ST_DONE) |=> !slot_valid_q[$past(slot_q)])
		else $error("dropped slot still valid");

	// a search hit is always reported with ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_q.found) |-> (rsp_q.status == STAT_OK))
		else $error("found with error status");

	// a drop never counts more entries than a relation holds
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(rem_q) <= 32'(BLOCKS)))
		else $error("drop count overflow");

endmodule

/* bench/tb.sv */
module tb;
	import fsmt_pkg::*;

	localparam int SLOTS   = DEF_REL_SLOTS;
	localparam int NBLK    = DEF_BLOCKS;
	localparam int KEYS    = 12;
	localparam int MAX_GAP = 17;
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CAT_W-1:0] cfg_wdata;

	fsmt_req_if req_ch ();
	fsmt_rsp_if rsp_ch ();

	free_space_map_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// shadow of the map
	logic [CAT_W-1:0] clamp_cat;
	bit               rel_used [SLOTS];
	key_t             rel_key  [SLOTS];
	bit               blk_held [SLOTS][NBLK];
	logic [CAT_W-1:0] blk_cat  [SLOTS][NBLK];

	key_t   key_pool [KEYS];
	rsp_t   pending_rsp [$];
	int     mismatches;
	bit     no_idle;
	int     hold_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 10000000);
		$display("** free_space_map_table_unit: FAILED **");
		$finish;
	end

	function automatic int find_rel(key_t k);
		for (int s = 0; s < SLOTS; s++)
			if (rel_used[s] && rel_key[s] == k)
				return s;
		return -1;
	endfunction

	// expected result of one command, updating the shadow
	function automatic rsp_t map_result(req_t r);
		rsp_t o;
		key_t k;
		int s;
		int n;
		o.status = STAT_OK;
		o.found = 1'b0;
		o.found_block = NO_BLOCK;
		o.removed_count = '0;
		k = '{r.tablespace_id, r.database_id, r.relation_number};
		s = find_rel(k);
		case (r.cmd)
			CMD_RECORD: begin
				if (r.block >= NBLK) begin
					o.status = STAT_OOR;
				end else begin
					if (s < 0) begin
						for (int i = SLOTS - 1; i >= 0; i--)
							if (!rel_used[i]) s = i;
						if (s >= 0) begin
							rel_used[s] = 1'b1;
							rel_key[s] = k;
						end
					end
					if (s < 0) begin
						o.status = STAT_FULL;
					end else begin
						blk_held[s][r.block] = 1'b1;
						blk_cat[s][r.block] = (r.category > clamp_cat) ? clamp_cat : r.category;
					end
				end
			end
			CMD_SEARCH: begin
				if (s >= 0)
					for (int b = 0; b < NBLK; b++)
						if (!o.found && blk_held[s][b] && blk_cat[s][b] >= r.category) begin
							o.found = 1'b1;
							o.found_block = 32'(b);
						end
			end
			CMD_TRUNCATE: begin
				if (s >= 0 && r.block < NBLK)
					for (int b = int'(r.block); b < NBLK; b++)
						blk_held[s][b] = 1'b0;
			end
			CMD_DROP: begin
				if (s >= 0) begin
					n = 0;
					for (int b = 0; b < NBLK; b++) begin
						if (blk_held[s][b]) n++;
						blk_held[s][b] = 1'b0;
					end
					o.removed_count = 9'(n);
					rel_used[s] = 1'b0;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					rel_used[i] = 1'b0;
					for (int b = 0; b < NBLK; b++)
						blk_held[i][b] = 1'b0;
				end
			end
			default: ;
		endcase
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (rel_used[i]) n++;
		o.relation_count = 4'(n);
		return o;
	endfunction

	// result side: random stalls per transfer, plus long hold-off on request
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rsp_ch.valid && rsp_ch.ready)
					stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end
		end
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status || got.found !== want.found ||
				    got.found_block !== want.found_block ||
				    got.removed_count !== want.removed_count ||
				    got.relation_count !== want.relation_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_cmd(req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(negedge clk);
		while (!req_ch.ready) @(negedge clk);
		@(posedge clk);
		pending_rsp = {pending_rsp, map_result(r)};
	endtask

	task automatic send_fields(logic [2:0] c, key_t k, logic [31:0] b, logic [CAT_W-1:0] cat);
		req_t r;
		r.cmd = c;
		r.tablespace_id = k.tablespace_id;
		r.database_id = k.database_id;
		r.relation_number = k.relation_number;
		r.block = b;
		r.category = cat;
		send_cmd(r);
	endtask

	task automatic drain;
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic write_clamp(logic [CAT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		clamp_cat = v;
	endtask

	function automatic req_t random_cmd();
		req_t r;
		int p;
		key_t k;
		p = $urandom_range(0, 199);
		if (p < 100) r.cmd = CMD_RECORD;
		else if (p < 140) r.cmd = CMD_SEARCH;
		else if (p < 162) r.cmd = CMD_TRUNCATE;
		else if (p < 187) r.cmd = CMD_DROP;
		else if (p < 189) r.cmd = CMD_CLEAR;
		else r.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		if ($urandom_range(0, 9) != 0)
			k = key_pool[$urandom_range(0, KEYS - 1)];
		else
			k = '{$urandom, $urandom, $urandom};
		r.tablespace_id = k.tablespace_id;
		r.database_id = k.database_id;
		r.relation_number = k.relation_number;
		p = $urandom_range(0, 19);
		if (p < 16) r.block = $urandom_range(0, r.cmd == CMD_TRUNCATE ? NBLK + 40 : NBLK - 1);
		else if (p < 18) r.block = $urandom;
		else if (p < 19) r.block = NBLK;
		else r.block = NO_BLOCK;
		r.category = CAT_W'($urandom);
		return r;
	endfunction

	task automatic test_directed;
		key_t z;
		key_t o;
		z = '0;
		o = '1;
		send_fields(CMD_SEARCH, z, 0, 0);              // unknown relation
		send_fields(CMD_TRUNCATE, z, 0, 0);
		send_fields(CMD_DROP, o, 0, 0);
		send_fields(CMD_RECORD, z, 0, 0);
		send_fields(CMD_RECORD, z, NBLK - 1, '1);
		send_fields(CMD_RECORD, o, NBLK, 8'h40);       // out of range
		send_fields(CMD_RECORD, o, NO_BLOCK, 8'h40);
		send_fields(CMD_RECORD, o, 7, 8'h40);
		send_fields(CMD_SEARCH, z, 0, 0);
		send_fields(CMD_SEARCH, z, 0, '1);
		send_fields(CMD_SEARCH, o, 0, 8'h41);          // no match
		send_fields(CMD_TRUNCATE, z, NBLK, 0);         // count too large
		send_fields(CMD_SEARCH, z, 0, '1);
		send_fields(CMD_TRUNCATE, z, 1, 0);
		send_fields(CMD_SEARCH, z, 0, '1);
		send_fields(CMD_UNUSED_LO, z, 0, 0);
		send_fields(CMD_UNUSED_HI, o, 0, 0);
		// fill every slot then one more relation
		for (int i = 0; i < SLOTS; i++)
			send_fields(CMD_RECORD, key_pool[i], i, CAT_W'(i));
		send_fields(CMD_RECORD, key_pool[SLOTS], 3, 8'h10);
		send_fields(CMD_DROP, o, 0, 0);
		send_fields(CMD_CLEAR, z, 0, 0);
	endtask

	task automatic test_clamp_settings;
		logic [CAT_W-1:0] vals [4];
		vals = '{8'd0, 8'd128, 8'd255, 8'd0};
		vals[3] = CAT_W'($urandom);
		foreach (vals[i]) begin
			write_clamp(vals[i]);
			for (int j = 0; j < 25; j++)
				send_cmd(random_cmd());
		end
		write_clamp(8'd255);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 50) no_idle = ~no_idle;
			send_cmd(random_cmd());
		end
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure;
		drain();
		no_idle = 1'b1;
		hold_cycles = 600;
		for (int i = 0; i < 40; i++)
			send_cmd(random_cmd());
		no_idle = 1'b0;
	endtask

	task automatic test_pause;
		for (int i = 0; i < 30; i++)
			send_cmd(random_cmd());
		drain();
		for (int i = 0; i < 30; i++)
			send_cmd(random_cmd());
	endtask

	initial begin
		mismatches = 0;
		no_idle = 1'b0;
		hold_cycles = 0;
		clamp_cat = 8'd255;
		foreach (rel_used[i]) rel_used[i] = 1'b0;
		foreach (blk_held[i, b]) blk_held[i][b] = 1'b0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEYS; i++)
			key_pool[i] = '{$urandom, $urandom, $urandom};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_clamp_settings();
		test_backpressure();
		test_pause();
		test_random(560);

		drain();
		repeat (NBLK + 20) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("** free_space_map_table_unit: PASSED **");
		else
			$display("** free_space_map_table_unit: FAILED **");
		$finish;
	end

endmodule
